[rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// Three stacks package
// Shared types, codes and constants for the three-stack shared word memory.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned MemDepthDefault = 64;
  localparam int unsigned NumStacks       = 3;
  localparam int unsigned WordW           = 32;
  localparam int unsigned CfgW            = 6;
  localparam int unsigned CntW            = 7;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned SelW            = 2;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusDone      = 2'd0,
    StatusOverflow  = 2'd1,
    StatusUnderflow = 2'd2
  } status_e;

  typedef logic [CfgW-1:0] cfg_word_t;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgBaseOne    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitOne   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBaseTwo    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLimitTwo   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBaseThree  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLimitThree = 3'd5;

  localparam cfg_word_t BaseOneReset    = 6'd0;
  localparam cfg_word_t LimitOneReset   = 6'd15;
  localparam cfg_word_t BaseTwoReset    = 6'd16;
  localparam cfg_word_t LimitTwoReset   = 6'd32;
  localparam cfg_word_t BaseThreeReset  = 6'd33;
  localparam cfg_word_t LimitThreeReset = 6'd49;

  typedef struct packed {
    cmd_e                    command;
    logic [SelW-1:0]         stack_select;
    logic signed [WordW-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] pop_value;
    status_e                 status;
    logic                    now_empty;
    logic                    now_full;
  } out_item_t;

  // Partition of one stack.
  typedef struct packed {
    cfg_word_t base;
    cfg_word_t limit;
  } part_t;

  // Outcome of one operation, apart from the popped word.
  typedef struct packed {
    logic    pop_ok;
    status_e status;
    logic    now_empty;
    logic    now_full;
  } op_res_t;

endpackage

[rtl/three_stacks_shared_memory.sv]
// An accepted item is held in the input register; its result and any popped word are
// then registered in the result register and in the word memory's read register.
// Throughput: one item per cycle while the output is not stalled; the input register,
// the single-port word memory and the result register each take an item every cycle.
// Reset: asynchronous, active low; clears the fill counts and the pipeline
// valid bits and loads the partition registers with their default layout.
// ----------------------------------------------------------------------------
// Three stacks in a shared memory
// Push and pop on three stacks kept in one word memory, with partitions set through the configuration port.
// ----------------------------------------------------------------------------
module three_stacks_shared_memory #(
  parameter int unsigned MemDepth = tss_pkg::MemDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tss_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tss_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  tss_pkg::cfg_word_t            cfg_data_i
);
  import tss_pkg::*;

  localparam int unsigned AddrW = $clog2(MemDepth);

  logic             s_valid_q;
  in_item_t         s_item_q;
  logic             out_valid_q;
  op_res_t          res_q;
  op_res_t          res;
  part_t            part;
  logic             adv;
  logic             op_en;
  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [WordW-1:0] rdata;

  // The stage moves on whenever the result register is free or being taken.
  assign adv        = !out_valid_q || !out_stall_i;
  assign op_en      = s_valid_q && adv;
  assign in_stall_o = s_valid_q && !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s_item_q <= in_item_i;
    end
    if (op_en) begin
      res_q <= res;
    end
  end

  tss_cfg_regs u_cfg_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .stack_select_i (s_item_q.stack_select),
    .part_o         (part)
  );

  tss_stack_ctrl #(
    .MemDepth (MemDepth)
  ) u_stack_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_en_i    (op_en),
    .item_i     (s_item_q),
    .part_i     (part),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr)
  );

  tss_word_mem #(
    .MemDepth (MemDepth)
  ) u_word_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (s_item_q.push_value),
    .rdata_o (rdata)
  );

  // The read data is only loaded by a successful pop, so it is masked otherwise.
  assign out_valid_o          = out_valid_q;
  assign out_item_o.pop_value = res_q.pop_ok ? rdata : '0;
  assign out_item_o.status    = res_q.status;
  assign out_item_o.now_empty = res_q.now_empty;
  assign out_item_o.now_full  = res_q.now_full;

endmodule

[rtl/tss_word_mem.sv]
// ----------------------------------------------------------------------------
// Shared word memory
// Single-port word store with a registered read port.
// ----------------------------------------------------------------------------
module tss_word_mem #(
  parameter int unsigned MemDepth = tss_pkg::MemDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [$clog2(MemDepth)-1:0]  addr_i,
  input  logic [tss_pkg::WordW-1:0]    wdata_i,
  output logic [tss_pkg::WordW-1:0]    rdata_o
);
  import tss_pkg::*;

  logic [WordW-1:0] mem_q [MemDepth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tss_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Partition registers
// Base and limit registers of the three stacks, with the selected stack's
// partition presented to the operation logic.
// ----------------------------------------------------------------------------
module tss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  tss_pkg::cfg_word_t            cfg_data_i,
  input  logic [tss_pkg::SelW-1:0]      stack_select_i,
  output tss_pkg::part_t                part_o
);
  import tss_pkg::*;

  part_t part_q [NumStacks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q[0] <= '{base: BaseOneReset,   limit: LimitOneReset};
      part_q[1] <= '{base: BaseTwoReset,   limit: LimitTwoReset};
      part_q[2] <= '{base: BaseThreeReset, limit: LimitThreeReset};
    end else if (cfg_valid_i) begin
      // Indexes beyond the register list are dropped.
      case (cfg_index_i)
        CfgBaseOne:    part_q[0].base  <= cfg_data_i;
        CfgLimitOne:   part_q[0].limit <= cfg_data_i;
        CfgBaseTwo:    part_q[1].base  <= cfg_data_i;
        CfgLimitTwo:   part_q[1].limit <= cfg_data_i;
        CfgBaseThree:  part_q[2].base  <= cfg_data_i;
        CfgLimitThree: part_q[2].limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    part_o = '0;
    for (int i = 0; i < NumStacks; i++) begin
      if (stack_select_i == SelW'(i)) begin
        part_o = part_q[i];
      end
    end
  end

endmodule

[rtl/tss_stack_ctrl.sv]
// ----------------------------------------------------------------------------
// Stack control
// Fill counts, overflow and underflow checks, and the memory address of
// each push or pop.
// ----------------------------------------------------------------------------
module tss_stack_ctrl #(
  parameter int unsigned MemDepth = tss_pkg::MemDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_en_i,
  input  tss_pkg::in_item_t             item_i,
  input  tss_pkg::part_t                part_i,
  output tss_pkg::op_res_t              res_o,
  output logic                          mem_we_o,
  output logic                          mem_re_o,
  output logic [$clog2(MemDepth)-1:0]   mem_addr_o
);
  import tss_pkg::*;

  localparam int unsigned AddrW   = $clog2(MemDepth);
  localparam int unsigned LutSize = 2 ** CntW;

  logic [CntW-1:0]  cnt_q [NumStacks];
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  cnt_next;
  logic [CntW-1:0]  cap;
  logic [CntW-1:0]  addr_sum;
  logic [AddrW-1:0] mod_lut [LutSize];
  logic             sel_ok;
  logic             is_pop;
  logic             push_ok;
  logic             pop_ok;

  // Address wrap around the store, worked out at elaboration.
  for (genvar i = 0; i < LutSize; i++) begin : g_mod_lut
    assign mod_lut[i] = AddrW'(i % MemDepth);
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < NumStacks; i++) begin
      if (item_i.stack_select == SelW'(i)) begin
        cnt = cnt_q[i];
      end
    end
  end

  assign sel_ok = item_i.stack_select < SelW'(NumStacks);
  assign is_pop = item_i.command == CmdPop;

  // A limit below the base leaves the stack without room.
  assign cap = (part_i.limit < part_i.base) ? '0
             : ({1'b0, part_i.limit} - {1'b0, part_i.base} + CntW'(1));

  assign push_ok = !is_pop && (cnt < cap);
  assign pop_ok  = is_pop && (cnt != '0);

  always_comb begin
    if (push_ok) begin
      cnt_next = cnt + CntW'(1);
    end else if (pop_ok) begin
      cnt_next = cnt - CntW'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  // A push writes at base + count, a pop reads at base + count - 1.
  assign addr_sum   = {1'b0, part_i.base} + cnt - CntW'(is_pop);
  assign mem_addr_o = mod_lut[addr_sum];
  assign mem_we_o   = op_en_i && sel_ok && push_ok;
  assign mem_re_o   = op_en_i && sel_ok && pop_ok;

  always_comb begin
    if (!sel_ok) begin
      res_o.pop_ok    = 1'b0;
      res_o.status    = is_pop ? StatusUnderflow : StatusOverflow;
      res_o.now_empty = 1'b1;
      res_o.now_full  = 1'b1;
    end else begin
      res_o.pop_ok = pop_ok;
      if (is_pop) begin
        res_o.status = pop_ok ? StatusDone : StatusUnderflow;
      end else begin
        res_o.status = push_ok ? StatusDone : StatusOverflow;
      end
      res_o.now_empty = cnt_next == '0;
      res_o.now_full  = cnt_next >= cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStacks; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (op_en_i) begin
      for (int i = 0; i < NumStacks; i++) begin
        if (item_i.stack_select == SelW'(i)) begin
          cnt_q[i] <= cnt_next;
        end
      end
    end
  end

endmodule

[rtl/tss_checker.sv]
// ----------------------------------------------------------------------------
// Three stacks port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module tss_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tss_pkg::out_item_t   out_item_o
);
  import tss_pkg::*;

  // A refused pop hands back nothing and leaves the stack empty.
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == StatusUnderflow
      |-> out_item_o.pop_value == '0 && out_item_o.now_empty)
    else $error("underflow item with a value or a non-empty stack");

  // A refused push is always reported with the stack full.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == StatusOverflow |-> out_item_o.now_full)
    else $error("overflow item on a stack that is not full");

  // Every result item carries one of the three status codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status == StatusDone
                 || out_item_o.status == StatusOverflow
                 || out_item_o.status == StatusUnderflow)
    else $error("result item carries an unknown status");

  // The input side is held back only by a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

endmodule

bind three_stacks_shared_memory tss_checker u_tss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
